### rtl/core/histogram_largest_rectangle_unit_assert.svh
// assertion macros for the histogram largest rectangle unit
`ifndef HISTOGRAM_LARGEST_RECTANGLE_UNIT_ASSERT_SVH
`define HISTOGRAM_LARGEST_RECTANGLE_UNIT_ASSERT_SVH

// cause in the same cycle implies effect
`define HLR_ASSERT_SAME(label, clk, rst, cause, effect, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cause) |-> (effect)) \
      else $error(msg);

// cause implies effect in the next cycle
`define HLR_ASSERT_NEXT(label, clk, rst, cause, effect, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
      else $error(msg);

`endif

### rtl/core/hlr_pkg.sv
// shared types and constants for the histogram largest rectangle unit
package hlr_pkg;

   localparam int HLR_MAX_BARS    = 4096;
   localparam int HLR_HEIGHT_BITS = 30;
   localparam int HEIGHT_W        = 30;
   localparam int AREA_W          = 42;

   typedef struct packed {
      logic [HEIGHT_W-1:0] height;
      logic                last;
   } req_payload_type;

   typedef struct packed {
      logic [AREA_W-1:0] area;
      logic              overflow;
   } rsp_payload_type;

   typedef struct packed {
      logic issue;
      logic clear;
   } score_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_POP_RD,
      ST_FLUSH,
      ST_FLUSH_RD,
      ST_DRAIN,
      ST_DONE
   } hlr_state_type;

endpackage

### rtl/core/hlr_stack_mem.sv
// stack storage below the cached top entry, one write and one read per cycle
module hlr_stack_mem #(
   parameter int MAX_BARS    = hlr_pkg::HLR_MAX_BARS,
   parameter int HEIGHT_BITS = hlr_pkg::HLR_HEIGHT_BITS
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(MAX_BARS)-1:0]   wr_addr,
   input  logic [HEIGHT_BITS-1:0]        wr_height,
   input  logic [$clog2(MAX_BARS)-1:0]   wr_start,
   input  logic                          rd_en,
   input  logic [$clog2(MAX_BARS)-1:0]   rd_addr,
   output logic [HEIGHT_BITS-1:0]        rd_height,
   output logic [$clog2(MAX_BARS)-1:0]   rd_start
);
   import hlr_pkg::*;

   localparam int IDX_W   = $clog2(MAX_BARS);
   localparam int ENTRY_W = HEIGHT_BITS + IDX_W;

   logic [ENTRY_W-1:0] mem_ff [MAX_BARS];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= {wr_height, wr_start};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_height = rd_data_ff[ENTRY_W-1:IDX_W];
   assign rd_start  = rd_data_ff[IDX_W-1:0];

endmodule

### rtl/core/hlr_score_unit.sv
// shared scoring multiplier with running maximum
module hlr_score_unit #(
   parameter int MAX_BARS    = hlr_pkg::HLR_MAX_BARS,
   parameter int HEIGHT_BITS = hlr_pkg::HLR_HEIGHT_BITS
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  hlr_pkg::score_ctl_type                        ctl,
   input  logic [HEIGHT_BITS-1:0]                        op_height,
   input  logic [$clog2(MAX_BARS+1)-1:0]                 op_width,
   output logic [HEIGHT_BITS+$clog2(MAX_BARS+1)-1:0]     best,
   output logic                                          busy
);
   import hlr_pkg::*;

   localparam int CNT_W  = $clog2(MAX_BARS+1);
   localparam int PROD_W = HEIGHT_BITS + CNT_W;

   logic [HEIGHT_BITS-1:0] a_ff;
   logic [CNT_W-1:0]       b_ff;
   logic                   go_ff;
   logic [PROD_W-1:0]      prod_ff;
   logic                   prod_go_ff;
   logic [PROD_W-1:0]      best_ff;
   logic [PROD_W-1:0]      best_in;

   // operand register, then product register, then compare
   always_ff @(posedge clock) begin
      if (ctl.issue) begin
         a_ff <= op_height;
         b_ff <= op_width;
      end
      if (go_ff) begin
         prod_ff <= PROD_W'(a_ff) * PROD_W'(b_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         go_ff      <= 1'b0;
         prod_go_ff <= 1'b0;
      end else begin
         go_ff      <= ctl.issue;
         prod_go_ff <= go_ff;
      end
   end

   always_comb begin
      best_in = best_ff;
      if (ctl.clear) begin
         best_in = '0;
      end else if (prod_go_ff && (prod_ff > best_ff)) begin
         best_in = prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff <= '0;
      end else begin
         best_ff <= best_in;
      end
   end

   assign best = best_ff;
   assign busy = go_ff | prod_go_ff;

endmodule

### rtl/core/histogram_largest_rectangle_unit.sv
// top level: streamed largest rectangle in a histogram over a monotonic stack
//
//   channel   ports                          payload                 direction
//   request   req_valid req_stall req_data   height, last            in
//   response  rsp_valid rsp_stall rsp_data   area, overflow          out
//
// a bar is accepted, pops each entry it covers (each pop but the bottom one reads the
// next entry from memory) and is pushed; a bar past the bar limit is dropped; a last
// bar then flushes each remaining entry the same way, drains the shared multiplier and
// posts the result, later while an earlier result still waits on rsp_stall
// reset clears the counters and the running best; the stack needs no clearing pass
// a new bar is taken while a posted result still waits on rsp_stall
module histogram_largest_rectangle_unit #(
   parameter int MAX_BARS    = hlr_pkg::HLR_MAX_BARS,
   parameter int HEIGHT_BITS = hlr_pkg::HLR_HEIGHT_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  hlr_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output hlr_pkg::rsp_payload_type rsp_data
);
   import hlr_pkg::*;

   localparam int IDX_W  = $clog2(MAX_BARS);
   localparam int CNT_W  = $clog2(MAX_BARS+1);
   localparam int PROD_W = HEIGHT_BITS + CNT_W;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BARS);

   `include "histogram_largest_rectangle_unit_assert.svh"

   // sequencer
   hlr_state_type state_ff, state_in;

   // bar being placed
   logic [HEIGHT_BITS-1:0] h_ff;
   logic                   last_ff;
   logic [IDX_W-1:0]       start_ff;

   // stack bookkeeping, top entry kept in flops
   logic [CNT_W-1:0]       depth_ff;
   logic [CNT_W-1:0]       bar_count_ff;
   logic                   overflowed_ff;
   logic [HEIGHT_BITS-1:0] top_h_ff;
   logic [IDX_W-1:0]       top_s_ff;

   // output register
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;

   // strobes from the handshake logic and the output decoder
   logic          accept;
   logic          over_full;
   logic          stack_hit;
   logic          do_pop;
   logic          do_push;
   logic          do_fpop;
   logic          top_load;
   logic          do_done;
   logic          rsp_free;
   score_ctl_type score_ctl;
   logic          mem_we;
   logic          mem_re;
   logic [IDX_W-1:0] mem_waddr;
   logic [IDX_W-1:0] mem_raddr;

   // memory and score unit returns, and the score width
   logic [HEIGHT_BITS-1:0] mem_rd_height;
   logic [IDX_W-1:0]       mem_rd_start;
   logic [PROD_W-1:0]      best;
   logic                   score_busy;
   logic [CNT_W-1:0]       score_width;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign over_full = (bar_count_ff == CNT_MAX);
   assign stack_hit = (depth_ff != '0) && (top_h_ff >= h_ff);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // width of the popped entry: bar index while placing, bar count while flushing
   assign score_width = bar_count_ff - CNT_W'(top_s_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (over_full) begin
                  state_in = req_data.last ? ST_FLUSH : ST_IDLE;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (stack_hit) begin
               state_in = (depth_ff > CNT_W'(1)) ? ST_POP_RD : ST_CHECK;
            end else begin
               state_in = last_ff ? ST_FLUSH : ST_IDLE;
            end
         end
         ST_POP_RD: begin
            state_in = ST_CHECK;
         end
         ST_FLUSH: begin
            if (depth_ff != '0) begin
               state_in = (depth_ff > CNT_W'(1)) ? ST_FLUSH_RD : ST_FLUSH;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_FLUSH_RD: begin
            state_in = ST_FLUSH;
         end
         ST_DRAIN: begin
            if (!score_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output decoder
   always_comb begin
      do_pop    = 1'b0;
      do_push   = 1'b0;
      do_fpop   = 1'b0;
      top_load  = 1'b0;
      do_done   = 1'b0;
      score_ctl = '0;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = IDX_W'(depth_ff - CNT_W'(1));
      mem_raddr = IDX_W'(depth_ff - CNT_W'(2));
      unique case (state_ff)
         ST_CHECK: begin
            if (stack_hit) begin
               do_pop          = 1'b1;
               score_ctl.issue = 1'b1;
               mem_re          = (depth_ff > CNT_W'(1));
            end else begin
               do_push = 1'b1;
               // old top spills into memory below the new one
               mem_we  = (depth_ff != '0);
            end
         end
         ST_FLUSH: begin
            if (depth_ff != '0) begin
               do_fpop         = 1'b1;
               score_ctl.issue = 1'b1;
               mem_re          = (depth_ff > CNT_W'(1));
            end
         end
         ST_POP_RD, ST_FLUSH_RD: begin
            top_load = 1'b1;
         end
         ST_DONE: begin
            if (rsp_free) begin
               do_done         = 1'b1;
               score_ctl.clear = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // bar registers and cached top
   always_ff @(posedge clock) begin
      if (accept) begin
         h_ff     <= HEIGHT_BITS'(req_data.height);
         last_ff  <= req_data.last;
         start_ff <= IDX_W'(bar_count_ff);
      end else if (do_pop) begin
         // new bar inherits the start of the entry it covers
         start_ff <= top_s_ff;
      end
      if (do_push) begin
         top_h_ff <= h_ff;
         top_s_ff <= start_ff;
      end else if (top_load) begin
         top_h_ff <= mem_rd_height;
         top_s_ff <= mem_rd_start;
      end
   end

   // counters and flags
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff      <= '0;
         bar_count_ff  <= '0;
         overflowed_ff <= 1'b0;
      end else if (do_done) begin
         depth_ff      <= '0;
         bar_count_ff  <= '0;
         overflowed_ff <= 1'b0;
      end else begin
         if (accept && over_full) begin
            overflowed_ff <= 1'b1;
         end
         if (do_pop || do_fpop) begin
            depth_ff <= depth_ff - CNT_W'(1);
         end else if (do_push) begin
            depth_ff     <= depth_ff + CNT_W'(1);
            bar_count_ff <= bar_count_ff + CNT_W'(1);
         end
      end
   end

   // result register, parts the sequencer from the response side
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (do_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_done) begin
         rsp_data_ff.area     <= overflowed_ff ? '0 : AREA_W'(best);
         rsp_data_ff.overflow <= overflowed_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   hlr_stack_mem #(
      .MAX_BARS    (MAX_BARS),
      .HEIGHT_BITS (HEIGHT_BITS)
   ) u_stack_mem (
      .clock     (clock),
      .wr_en     (mem_we),
      .wr_addr   (mem_waddr),
      .wr_height (top_h_ff),
      .wr_start  (top_s_ff),
      .rd_en     (mem_re),
      .rd_addr   (mem_raddr),
      .rd_height (mem_rd_height),
      .rd_start  (mem_rd_start)
   );

   hlr_score_unit #(
      .MAX_BARS    (MAX_BARS),
      .HEIGHT_BITS (HEIGHT_BITS)
   ) u_score_unit (
      .clock     (clock),
      .reset     (reset),
      .ctl       (score_ctl),
      .op_height (top_h_ff),
      .op_width  (score_width),
      .best      (best),
      .busy      (score_busy)
   );

   // stack never holds more entries than bars placed
   `HLR_ASSERT_SAME(a_depth_bound, clock, reset, 1'b1, depth_ff <= bar_count_ff, "stack deeper than bar count")
   // overflow only once the bar count is full
   `HLR_ASSERT_SAME(a_overflow_full, clock, reset, overflowed_ff, bar_count_ff == CNT_MAX, "overflow below capacity")
   // a posted transaction leaves the unit cleared for the next histogram
   `HLR_ASSERT_NEXT(a_done_clears, clock, reset, do_done, (depth_ff == '0) && (bar_count_ff == '0) && !score_busy && rsp_valid_ff, "unit not cleared after result")

endmodule

### test/histogram_largest_rectangle_unit_test.sv
// testbench for the histogram largest rectangle unit: streamed bars checked against a stack predictor
module histogram_largest_rectangle_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import hlr_pkg::*;

   localparam int                  MAX_BARS    = HLR_MAX_BARS;
   localparam logic [HEIGHT_W-1:0] HEIGHT_MAX  = '1;
   localparam int                  RANDOM_BARS = 520;
   localparam int                  TAIL_CYCLES = 16;
   localparam int                  CYCLE_LIMIT = 1_000_000;

   // how the heights of one random histogram are spread
   typedef enum int {
      SPREAD_FULL,
      SPREAD_LOW,
      SPREAD_EDGES,
      SPREAD_NEAR
   } spread_type;

   // tracks the running stack of one histogram and the areas still owed by the block
   class histogram_tracker;
      logic [HEIGHT_W-1:0] heights [MAX_BARS];
      logic [11:0]         starts  [MAX_BARS];
      int unsigned         depth;
      int unsigned         count;
      logic [63:0]         best;
      logic                dropped;
      rsp_payload_type     areas_due [$];
      int unsigned         misses;
      int unsigned         checked;
      int unsigned         bars;
      int unsigned         histograms;
      int unsigned         overflows;
      int unsigned         peak_depth;
      logic [AREA_W-1:0]   peak_area;

      function void restart();
         depth   = 0;
         count   = 0;
         best    = '0;
         dropped = 1'b0;
      endfunction

      function new();
         peak_area = '0;
         restart();
      endfunction

      function void score(logic [HEIGHT_W-1:0] h, int unsigned w);
         logic [63:0] a;
         a = 64'(h) * 64'(w);
         if (a > best) best = a;
      endfunction

      // one accepted bar; a last bar flushes the stack and owes one area
      function void take_bar(req_payload_type bar);
         int unsigned     idx;
         int unsigned     start;
         rsp_payload_type due;
         bars++;
         if (count >= MAX_BARS) begin
            dropped = 1'b1;
         end else begin
            idx   = count;
            start = idx;
            while (depth > 0 && heights[depth-1] >= bar.height) begin
               depth--;
               score(heights[depth], idx - starts[depth]);
               start = starts[depth];
            end
            if (depth < MAX_BARS) begin
               heights[depth] = bar.height;
               starts[depth]  = start[11:0];
               depth++;
            end
            count++;
            if (depth > peak_depth) peak_depth = depth;
         end
         if (bar.last) begin
            while (depth > 0) begin
               depth--;
               score(heights[depth], count - starts[depth]);
            end
            due.area     = dropped ? '0 : best[AREA_W-1:0];
            due.overflow = dropped;
            if (due.area > peak_area) peak_area = due.area;
            if (dropped) overflows++;
            histograms++;
            areas_due.insert(areas_due.size(), due);
            restart();
         end
      endfunction

      function void miss(string what);
         misses++;
         if (misses <= 10) $display("mismatch at result %0d: %s", checked, what);
      endfunction

      function void match_area(rsp_payload_type got);
         rsp_payload_type want;
         checked++;
         if (areas_due.size() == 0) begin
            miss($sformatf("area %0d overflow %0b with no histogram pending",
                           got.area, got.overflow));
            return;
         end
         want = areas_due.pop_front();
         if (got.area !== want.area)
            miss($sformatf("area expected %0d got %0d", want.area, got.area));
         if (got.overflow !== want.overflow)
            miss($sformatf("overflow expected %0b got %0b", want.overflow, got.overflow));
      endfunction

      function int pending();
         return areas_due.size();
      endfunction
   endclass

   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;

   // steady turns off idling on both sides for a long stretch
   logic             steady  = 1'b0;
   int unsigned      cycles  = 0;
   histogram_tracker tracker = new();

   histogram_largest_rectangle_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // result side: check each accepted transaction, then pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) tracker.match_area(rsp_data);
      rsp_stall <= !steady && ($urandom_range(99) < 11);
   end

   // watchdog on the whole run
   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   // offer one bar and hold it until the block takes it; random idle cycles go first
   task automatic send_bar(input logic [HEIGHT_W-1:0] h, input logic is_last);
      req_payload_type bar;
      bar.height = h;
      bar.last   = is_last;
      if (!steady && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < 11) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= bar;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.take_bar(bar);
   endtask

   // hold off the sender until every owed area has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   function automatic logic [HEIGHT_W-1:0] pick_height(spread_type spread,
                                                       logic [HEIGHT_W-1:0] base);
      case (spread)
         SPREAD_FULL: return HEIGHT_W'($urandom_range(HEIGHT_MAX, 0));
         SPREAD_LOW:  return HEIGHT_W'($urandom_range(7, 0));
         SPREAD_EDGES: begin
            case ($urandom_range(2))
               0:       return '0;
               1:       return HEIGHT_MAX;
               default: return HEIGHT_W'($urandom_range(HEIGHT_MAX, 0));
            endcase
         end
         default:     return base + HEIGHT_W'($urandom_range(15, 0));
      endcase
   endfunction

   initial begin
      int unsigned         random_bars;
      int unsigned         hist;
      int unsigned         len;
      spread_type          spread;
      logic [HEIGHT_W-1:0] base;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: single zero bar, single tallest bar
      send_bar('0, 1'b1);
      send_bar(HEIGHT_MAX, 1'b1);
      // zero height in the middle pops every earlier entry off the stack
      send_bar(30'd5, 1'b0);
      send_bar(30'd0, 1'b0);
      send_bar(30'd7, 1'b1);
      // rising run: nothing pops until the flush
      send_bar(30'd1, 1'b0);
      send_bar(30'd2, 1'b0);
      send_bar(30'd3, 1'b0);
      send_bar(30'd4, 1'b1);
      // falling run: every bar pops the one before
      send_bar(30'd4, 1'b0);
      send_bar(30'd3, 1'b0);
      send_bar(30'd2, 1'b0);
      send_bar(30'd1, 1'b1);
      // equal heights pop on ties and keep the old start
      send_bar(30'd6, 1'b0);
      send_bar(30'd6, 1'b0);
      send_bar(30'd6, 1'b1);
      // textbook shape, best area 10
      send_bar(30'd2, 1'b0);
      send_bar(30'd1, 1'b0);
      send_bar(30'd5, 1'b0);
      send_bar(30'd6, 1'b0);
      send_bar(30'd2, 1'b0);
      send_bar(30'd3, 1'b1);
      settle();

      // random histograms, mostly short, a few long; a run of them with no idling
      random_bars = 0;
      for (hist = 0; random_bars < RANDOM_BARS; hist++) begin
         steady <= (hist >= 10 && hist < 25);
         len    = ($urandom_range(99) < 90) ? $urandom_range(20, 1) : $urandom_range(120, 21);
         spread = spread_type'($urandom_range(3));
         base   = HEIGHT_W'($urandom_range(HEIGHT_MAX - 15, 0));
         for (int b = 0; b < len; b++) begin
            send_bar(pick_height(spread, base), b == len - 1);
            random_bars++;
         end
      end

      // drain, then give any stray result time to show up
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d bars in %0d histograms, %0d of them over the bar limit",
               tracker.bars, tracker.histograms, tracker.overflows);
      $display("stack reached %0d entries, largest area %0d, %0d results in %0d cycles",
               tracker.peak_depth, tracker.peak_area, tracker.checked, cycles);
      if (tracker.misses == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/hlr_pkg.sv
rtl/core/hlr_stack_mem.sv
rtl/core/hlr_score_unit.sv
rtl/core/histogram_largest_rectangle_unit.sv
test/histogram_largest_rectangle_unit_test.sv
